>>> sv/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

    // Fixed field widths
    localparam int BYTE_W           = 8;
    localparam int OUT_W            = 16;
    localparam int CAP_W            = 16;
    localparam int CP_W             = 16;
    localparam int HEX_CNT_W        = 3;
    localparam int LENGTH_WIDTH_DEF = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'd256;

    // Characters that steer the escape decoder
    localparam logic [BYTE_W-1:0] CHAR_BACKSLASH = 8'd92;
    localparam logic [BYTE_W-1:0] CHAR_N         = 8'd110;
    localparam logic [BYTE_W-1:0] CHAR_R         = 8'd114;
    localparam logic [BYTE_W-1:0] CHAR_T         = 8'd116;
    localparam logic [BYTE_W-1:0] CHAR_B         = 8'd98;
    localparam logic [BYTE_W-1:0] CHAR_F         = 8'd102;
    localparam logic [BYTE_W-1:0] CHAR_U         = 8'd117;
    localparam logic [BYTE_W-1:0] CHAR_QMARK     = 8'd63;

    // Control codes produced by the short escapes
    localparam logic [CP_W-1:0] CP_LF = 16'd10;
    localparam logic [CP_W-1:0] CP_CR = 16'd13;
    localparam logic [CP_W-1:0] CP_HT = 16'd9;
    localparam logic [CP_W-1:0] CP_BS = 16'd8;
    localparam logic [CP_W-1:0] CP_FF = 16'd12;

    // UTF-8 lead and continuation markers
    localparam logic [BYTE_W-1:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [BYTE_W-1:0] UTF8_CONT  = 8'h80;

    localparam logic [HEX_CNT_W-1:0] HEX_DIGITS_MAX = 3'd4;

    // Results caused by one input item: up to two data bytes and a closing result
    typedef struct packed {
        logic [BYTE_W-1:0] byte0;
        logic [BYTE_W-1:0] byte1;
        logic [OUT_W-1:0]  idx0;
        logic [OUT_W-1:0]  idx1;
        logic [OUT_W-1:0]  len;
        logic [1:0]        nbytes;
        logic              close;
    } t_bundle;

    // Value of one hex digit; anything else counts as zero
    function automatic logic [3:0] hex_nibble(input logic [BYTE_W-1:0] h);
        logic [3:0] v;
        v = 4'd0;
        if (h >= 8'd48 && h <= 8'd57) begin
            v = 4'(h - 8'd48);
        end else if (h >= 8'd97 && h <= 8'd102) begin
            v = 4'(h - 8'd87);
        end else if (h >= 8'd65 && h <= 8'd70) begin
            v = 4'(h - 8'd55);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> sv/jsu_engine.sv
`default_nettype none

module jsu_engine import jsu_pkg::*; #(
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [CAP_W-1:0]  i_cap,
    input  wire logic              i_step,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic              i_byte_present,
    input  wire logic              i_token_end,
    output t_bundle                o_bundle
);

    localparam int WIDE = ((LENGTH_WIDTH > CAP_W) ? LENGTH_WIDTH : CAP_W) + 2;

    logic                    r_esc, n_esc;
    logic                    r_uni, n_uni;
    logic [HEX_CNT_W-1:0]    r_cnt, n_cnt;
    logic [CP_W-1:0]         r_acc, n_acc;
    logic [LENGTH_WIDTH-1:0] r_pos, n_pos;
    logic                    r_full, n_full;

    logic                    emit_en;
    logic [CP_W-1:0]         cp;
    logic [CP_W-1:0]         acc_shift;
    logic [HEX_CNT_W-1:0]    cnt_inc;
    logic [WIDE-1:0]         pos_wide;
    logic [WIDE-1:0]         cap_wide;
    logic                    fits1, fits2;
    logic [1:0]              nb;
    logic [BYTE_W-1:0]       byte0, byte1;
    logic [LENGTH_WIDTH-1:0] pos_next1;
    logic [LENGTH_WIDTH-1:0] pos_after;
    logic [WIDE-1:0]         next1_wide, after_wide;

    // Room checks against the buffer capacity, done wide so nothing wraps
    assign pos_wide = WIDE'(r_pos);
    assign cap_wide = WIDE'(i_cap);
    assign fits1    = (pos_wide + WIDE'(1)) < cap_wide;
    assign fits2    = (pos_wide + WIDE'(2)) < cap_wide;

    assign acc_shift = {r_acc[CP_W-5:0], hex_nibble(i_data_byte)};
    assign cnt_inc   = r_cnt + HEX_CNT_W'(1);

    // Escape decoding and next state of the token
    always_comb begin
        n_esc   = r_esc;
        n_uni   = r_uni;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_full  = r_full;
        emit_en = 1'b0;
        cp      = '0;
        if (i_byte_present) begin
            if (r_esc) begin
                n_esc = 1'b0;
                case (i_data_byte)
                    CHAR_N: begin
                        emit_en = 1'b1;
                        cp      = CP_LF;
                    end
                    CHAR_R: begin
                        emit_en = 1'b1;
                        cp      = CP_CR;
                    end
                    CHAR_T: begin
                        emit_en = 1'b1;
                        cp      = CP_HT;
                    end
                    CHAR_B: begin
                        emit_en = 1'b1;
                        cp      = CP_BS;
                    end
                    CHAR_F: begin
                        emit_en = 1'b1;
                        cp      = CP_FF;
                    end
                    CHAR_U: begin
                        if (i_token_end) begin
                            emit_en = 1'b1;
                            cp      = '0;
                        end else begin
                            n_uni = 1'b1;
                            n_cnt = '0;
                            n_acc = '0;
                        end
                    end
                    default: begin
                        emit_en = 1'b1;
                        cp      = CP_W'(i_data_byte);
                    end
                endcase
            end else if (r_uni) begin
                n_acc = acc_shift;
                n_cnt = cnt_inc;
                if (cnt_inc >= HEX_DIGITS_MAX || i_token_end) begin
                    emit_en = 1'b1;
                    cp      = acc_shift;
                    n_uni   = 1'b0;
                    n_cnt   = '0;
                    n_acc   = '0;
                end
            end else if (r_full || !fits1) begin
                n_full = 1'b1;
            end else if (i_data_byte == CHAR_BACKSLASH && !i_token_end) begin
                n_esc = 1'b1;
            end else begin
                emit_en = 1'b1;
                cp      = CP_W'(i_data_byte);
            end
        end else if (i_token_end) begin
            // Close without a byte flushes an open escape.
            if (r_esc) begin
                emit_en = 1'b1;
                cp      = CP_W'(CHAR_BACKSLASH);
            end else if (r_uni) begin
                emit_en = 1'b1;
                cp      = r_acc;
            end
        end
    end

    // UTF-8 encoding of the emitted code point in one or two bytes, or '?' above 0x7FF, skipped when it does not fit
    always_comb begin
        nb    = 2'd0;
        byte0 = '0;
        byte1 = '0;
        if (emit_en) begin
            if (cp[CP_W-1:7] == '0) begin
                if (fits1) begin
                    nb    = 2'd1;
                    byte0 = cp[BYTE_W-1:0];
                end
            end else if (cp[CP_W-1:11] == '0) begin
                if (fits2) begin
                    nb    = 2'd2;
                    byte0 = UTF8_LEAD2 | {3'b000, cp[10:6]};
                    byte1 = UTF8_CONT | {2'b00, cp[5:0]};
                end
            end else if (fits1) begin
                nb    = 2'd1;
                byte0 = CHAR_QMARK;
            end
        end
    end

    assign pos_next1  = r_pos + LENGTH_WIDTH'(1);
    assign pos_after  = r_pos + LENGTH_WIDTH'(nb);
    assign next1_wide = WIDE'(pos_next1);
    assign after_wide = WIDE'(pos_after);

    // A token end clears everything but the capacity.
    assign n_pos = i_token_end ? '0 : pos_after;

    always_comb begin
        o_bundle.byte0  = byte0;
        o_bundle.byte1  = byte1;
        o_bundle.idx0   = pos_wide[OUT_W-1:0];
        o_bundle.idx1   = next1_wide[OUT_W-1:0];
        o_bundle.len    = after_wide[OUT_W-1:0];
        o_bundle.nbytes = nb;
        o_bundle.close  = i_token_end;
    end

    // Token state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc  <= 1'b0;
            r_uni  <= 1'b0;
            r_cnt  <= '0;
            r_acc  <= '0;
            r_pos  <= '0;
            r_full <= 1'b0;
        end else if (i_step) begin
            r_pos <= n_pos;
            if (i_token_end) begin
                r_esc  <= 1'b0;
                r_uni  <= 1'b0;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_full <= 1'b0;
            end else begin
                r_esc  <= n_esc;
                r_uni  <= n_uni;
                r_cnt  <= n_cnt;
                r_acc  <= n_acc;
                r_full <= n_full;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/jsu_out_buf.sv
`default_nettype none

module jsu_out_buf import jsu_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  t_bundle                i_bundle,
    output logic                   o_can_load,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [BYTE_W-1:0]      o_out_byte,
    output logic [OUT_W-1:0]       o_out_index,
    output logic                   o_string_done,
    output logic [OUT_W-1:0]       o_string_length
);

    t_bundle    r_bundle;
    logic       r_valid;
    logic [1:0] r_slot;
    logic [1:0] total;
    logic       last;
    logic       is_byte;
    logic       take;

    assign total   = r_bundle.nbytes + 2'(r_bundle.close);
    assign last    = (r_slot == total - 2'd1);
    assign is_byte = (r_slot < r_bundle.nbytes);
    assign take    = r_valid && i_ready;

    assign o_valid    = r_valid;
    assign o_can_load = !r_valid || (take && last);

    // Pick the pending result: data bytes first, then the closing result.
    always_comb begin
        if (is_byte) begin
            o_out_byte      = (r_slot == 2'd0) ? r_bundle.byte0 : r_bundle.byte1;
            o_out_index     = (r_slot == 2'd0) ? r_bundle.idx0 : r_bundle.idx1;
            o_string_done   = 1'b0;
            o_string_length = '0;
        end else begin
            o_out_byte      = '0;
            o_out_index     = r_bundle.len;
            o_string_done   = 1'b1;
            o_string_length = r_bundle.len;
        end
    end

    // Result register and slot pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= '0;
        end else if (i_load && o_can_load) begin
            r_valid <= 1'b1;
            r_slot  <= '0;
        end else if (take) begin
            if (last) begin
                r_valid <= 1'b0;
                r_slot  <= '0;
            end else begin
                r_slot <= r_slot + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_bundle <= i_bundle;
        end
    end

endmodule

`default_nettype wire

>>> sv/json_string_unescape_utf8_core.sv
`default_nettype none

// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+----------------------------------------
// input     | in        | i_valid / o_ready      | i_data_byte, i_byte_present, i_token_end
// result    | out       | o_valid / i_ready      | o_out_byte, o_out_index, o_string_done,
//           |           |                        | o_string_length
// config    | in        | i_cfg_valid/o_cfg_ready| i_cfg_data (capacity)
//
// An item passes an input register, then one pass of decode logic into the result register.
// An item that causes at most one result moves on every cycle while i_ready is high; one that
// causes two or three holds the input side as the result register drains, one per transfer.
// Reset is synchronous and active low; it clears the token state and sets capacity to 256.
// A stalled result side backs up into the input register and then drops o_ready.

module json_string_unescape_utf8_core import jsu_pkg::*; #(
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CAP_W-1:0]  i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic              i_byte_present,
    input  wire logic              i_token_end,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [BYTE_W-1:0]      o_out_byte,
    output logic [OUT_W-1:0]       o_out_index,
    output logic                   o_string_done,
    output logic [OUT_W-1:0]       o_string_length
);

    logic [CAP_W-1:0]  r_cap;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_pres;
    logic              r_in_end;
    t_bundle           bundle;
    logic              can_load;
    logic              step;
    logic              has_result;

    // Capacity register, written at any time the channel offers a transfer
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    // The held item is processed once the result register can take its results; one with no result goes at once.
    assign has_result = (bundle.nbytes != 2'd0) || bundle.close;
    assign step       = r_in_valid && (can_load || !has_result);
    assign o_ready    = !r_in_valid || step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
            r_in_pres <= i_byte_present;
            r_in_end  <= i_token_end;
        end
    end

    jsu_engine #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cap          (r_cap),
        .i_step         (step),
        .i_data_byte    (r_in_byte),
        .i_byte_present (r_in_pres),
        .i_token_end    (r_in_end),
        .o_bundle       (bundle)
    );

    jsu_out_buf u_out_buf (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (step && has_result),
        .i_bundle        (bundle),
        .o_can_load      (can_load),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_byte      (o_out_byte),
        .o_out_index     (o_out_index),
        .o_string_done   (o_string_done),
        .o_string_length (o_string_length)
    );

endmodule

`default_nettype wire
